// ===== rtl/core/b64e_pkg.sv =====
// b64e_pkg: shared types, constants and the symbol table of the base64 encoder
`timescale 1ns / 1ps

package b64e_pkg;

   // slot layout of one expanded request: prefix, two symbols, two pads, bel
   localparam int unsigned SlotCount  = 12;
   localparam int unsigned PrefixLen  = 7;
   localparam int unsigned SlotIdxW   = 4;
   localparam logic [SlotIdxW-1:0] SlotPrefixLast = 4'd6;
   localparam logic [SlotIdxW-1:0] SlotSym0       = 4'd7;
   localparam logic [SlotIdxW-1:0] SlotSym1       = 4'd8;
   localparam logic [SlotIdxW-1:0] SlotPad0       = 4'd9;
   localparam logic [SlotIdxW-1:0] SlotPad1       = 4'd10;
   localparam logic [SlotIdxW-1:0] SlotBel        = 4'd11;

   localparam logic [7:0] PadChar = 8'h3D;
   localparam logic [7:0] BelChar = 8'h07;

   // group phase codes
   localparam logic [1:0] PhaseStart = 2'd0;
   localparam logic [1:0] PhaseOne   = 2'd1;
   localparam logic [1:0] PhaseTwo   = 2'd2;

   typedef logic [SlotCount-1:0] slot_mask_type;
   typedef logic [SlotIdxW-1:0]  slot_idx_type;

   // one expanded request handed from the front end to the serializer
   typedef struct packed {
      slot_mask_type mask;
      logic [5:0]    sym0;
      logic [5:0]    sym1;
      logic          msg_last;
   } job_type;

   // osc 52 prefix: ESC ] 5 2 ; c ;
   function automatic logic [7:0] prefix_char(input slot_idx_type idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h1B;
         4'd1:    ch = 8'h5D;
         4'd2:    ch = 8'h35;
         4'd3:    ch = 8'h32;
         4'd4:    ch = 8'h3B;
         4'd5:    ch = 8'h63;
         4'd6:    ch = 8'h3B;
         default: ch = 8'h3B;
      endcase
      return ch;
   endfunction

   // standard base64 alphabet
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] ch;
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v < 6'd26) begin
         ch = v8 + 8'h41;
      end else if (v < 6'd52) begin
         ch = v8 - 8'd26 + 8'h61;
      end else if (v < 6'd62) begin
         ch = v8 - 8'd52 + 8'h30;
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

// ===== rtl/core/b64e_if.sv =====
// b64e_if: request and response channel interfaces of the base64 encoder
`timescale 1ns / 1ps

interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_data;
   logic       last_byte;

   modport source (output valid, output data_byte, output has_data, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input has_data, input last_byte,
                   output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       message_end;

   modport source (output valid, output out_char, output run_last, output message_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input message_end,
                   output ready);
endinterface

// ===== rtl/core/base64_osc52_encoder_unit.sv =====
// base64_osc52_encoder_unit: streaming base64 encoder with optional osc 52 wrapping
//
//   channel  dir  handshake           payload
//   req_if   in   valid/ready         data_byte[7:0], has_data, last_byte
//   rsp_if   out  valid/ready         out_char[7:0], run_last, message_end
//   csr      in   write enable only   csr_write_data = osc_wrap
//
// a request is expanded in the cycle it is accepted and its characters leave
// one per cycle from the output register while the response is not stalled.
// a request makes 0 to 12 characters (1 or 2 for a plain data byte, about
// 4/3 on average).
// the next request is accepted in the cycle the last character of the current
// one moves to the output register, so requests follow back to back.
// reset is synchronous: wrap enabled, no message open, nothing pending.
// a stalled response holds the output register and then the slot register.
`timescale 1ns / 1ps

module base64_osc52_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_if,
   b64e_rsp_if.source rsp_if,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   b64e_pkg::job_type job;
   logic              job_ready;
   logic              accept;

   // request accept
   assign accept       = req_if.valid && job_ready;
   assign req_if.ready = job_ready;

   // group state and expansion
   b64e_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_if.data_byte),
      .has_data         (req_if.has_data),
      .last_byte        (req_if.last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .job              (job)
   );

   // character serializer and output register
   b64e_serial u_serial (
      .clock           (clock),
      .reset           (reset),
      .load            (accept),
      .job_in          (job),
      .job_ready       (job_ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_char        (rsp_if.out_char),
      .rsp_run_last    (rsp_if.run_last),
      .rsp_message_end (rsp_if.message_end)
   );

endmodule

// ===== rtl/core/b64e_front.sv =====
// b64e_front: group state, wrap register and expansion of one request into slots
`timescale 1ns / 1ps

module b64e_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             has_data,
   input  logic             last_byte,
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   output b64e_pkg::job_type job
);

   logic       wrap_ff, wrap_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       open_ff, open_in;

   logic [1:0] ph_mid;
   logic [3:0] cr_mid;
   logic [5:0] sym_a, sym_b;
   logic       sym_a_vld, sym_b_vld;
   logic [5:0] flush_sym;
   logic       flush_vld;
   logic [1:0] pad_cnt;
   logic       active;

   // data part of the group, then flush and padding on close
   always_comb begin
      active    = has_data | last_byte;
      ph_mid    = phase_ff;
      cr_mid    = carry_ff;
      sym_a     = '0;
      sym_b     = '0;
      sym_a_vld = 1'b0;
      sym_b_vld = 1'b0;
      flush_sym = '0;
      flush_vld = 1'b0;
      pad_cnt   = 2'd0;

      if (has_data) begin
         case (phase_ff)
            b64e_pkg::PhaseOne: begin
               sym_a     = {carry_ff[1:0], data_byte[7:4]};
               sym_a_vld = 1'b1;
               cr_mid    = data_byte[3:0];
               ph_mid    = b64e_pkg::PhaseTwo;
            end
            b64e_pkg::PhaseTwo: begin
               sym_a     = {carry_ff, data_byte[7:6]};
               sym_b     = data_byte[5:0];
               sym_a_vld = 1'b1;
               sym_b_vld = 1'b1;
               cr_mid    = 4'd0;
               ph_mid    = b64e_pkg::PhaseStart;
            end
            default: begin
               // start of group, and the unused phase code
               sym_a     = data_byte[7:2];
               sym_a_vld = 1'b1;
               cr_mid    = {2'b00, data_byte[1:0]};
               ph_mid    = b64e_pkg::PhaseOne;
            end
         endcase
      end

      if (last_byte) begin
         case (ph_mid)
            b64e_pkg::PhaseOne: begin
               flush_sym = {cr_mid[1:0], 4'b0000};
               flush_vld = 1'b1;
               pad_cnt   = 2'd2;
            end
            b64e_pkg::PhaseTwo: begin
               flush_sym = {cr_mid, 2'b00};
               flush_vld = 1'b1;
               pad_cnt   = 2'd1;
            end
            default: begin
               flush_vld = 1'b0;
            end
         endcase
      end

      // pack symbols into the two symbol slots in order
      job.mask = '0;
      job.sym0 = sym_a;
      job.sym1 = sym_b;
      if (flush_vld) begin
         if (sym_a_vld) begin
            job.sym1 = flush_sym;
         end else begin
            job.sym0 = flush_sym;
         end
      end
      if (active) begin
         job.mask[b64e_pkg::PrefixLen-1:0] = {b64e_pkg::PrefixLen{~open_ff & wrap_ff}};
         job.mask[b64e_pkg::SlotSym0]      = sym_a_vld | flush_vld;
         job.mask[b64e_pkg::SlotSym1]      = sym_b_vld | (sym_a_vld & flush_vld);
         job.mask[b64e_pkg::SlotPad0]      = pad_cnt != 2'd0;
         job.mask[b64e_pkg::SlotPad1]      = pad_cnt == 2'd2;
         job.mask[b64e_pkg::SlotBel]       = last_byte & wrap_ff;
      end
      job.msg_last = last_byte;
   end

   // next state of the group
   always_comb begin
      wrap_in  = csr_write_enable ? csr_write_data : wrap_ff;
      phase_in = phase_ff;
      carry_in = carry_ff;
      open_in  = open_ff;
      if (accept && active) begin
         if (last_byte) begin
            phase_in = b64e_pkg::PhaseStart;
            carry_in = 4'd0;
            open_in  = 1'b0;
         end else begin
            phase_in = ph_mid;
            carry_in = cr_mid;
            open_in  = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff  <= 1'b1;
         phase_ff <= b64e_pkg::PhaseStart;
         carry_ff <= 4'd0;
         open_ff  <= 1'b0;
      end else begin
         wrap_ff  <= wrap_in;
         phase_ff <= phase_in;
         carry_ff <= carry_in;
         open_ff  <= open_in;
      end
   end

   // a closed message leaves no carry behind
   assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (phase_ff == b64e_pkg::PhaseStart && carry_ff == 4'd0))
      else $error("b64e_front: leftover bits with no message open");

   // the group phase code three never arises
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("b64e_front: unused group phase reached");

   // a closing request always ends the message
   assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> !open_ff)
      else $error("b64e_front: message still open after close");

endmodule

// ===== rtl/core/b64e_serial.sv =====
// b64e_serial: holds one expanded request and sends its characters one per cycle unless the response stalls
`timescale 1ns / 1ps

module b64e_serial (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  b64e_pkg::job_type job_in,
   output logic              job_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_char,
   output logic              rsp_run_last,
   output logic              rsp_message_end
);

   b64e_pkg::slot_mask_type mask_ff, mask_in;
   logic [5:0]              sym0_ff, sym1_ff;
   logic                    msg_last_ff;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff;
   logic       out_run_last_ff;
   logic       out_end_ff;

   b64e_pkg::slot_idx_type  idx;
   b64e_pkg::slot_mask_type low_bit;
   logic [7:0]              pick_char;
   logic                    busy;
   logic                    one_left;
   logic                    out_free;
   logic                    pop;

   // lowest pending slot
   always_comb begin
      idx = '0;
      for (int i = b64e_pkg::SlotCount - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            idx = b64e_pkg::slot_idx_type'(i);
         end
      end
      low_bit  = mask_ff & (~mask_ff + b64e_pkg::slot_mask_type'(1));
      busy     = mask_ff != '0;
      one_left = busy && ((mask_ff & ~low_bit) == '0);
   end

   // character of the chosen slot
   always_comb begin
      case (idx) inside
         [4'd0:b64e_pkg::SlotPrefixLast]: pick_char = b64e_pkg::prefix_char(idx);
         b64e_pkg::SlotSym0:              pick_char = b64e_pkg::b64_char(sym0_ff);
         b64e_pkg::SlotSym1:              pick_char = b64e_pkg::b64_char(sym1_ff);
         b64e_pkg::SlotPad0,
         b64e_pkg::SlotPad1:              pick_char = b64e_pkg::PadChar;
         default:                         pick_char = b64e_pkg::BelChar;
      endcase
   end

   // handshake between slot register and output register
   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      pop          = busy && out_free;
      job_ready    = !busy || (pop && one_left);
      out_valid_in = pop || (out_valid_ff && !rsp_ready);
      mask_in      = mask_ff;
      if (load) begin
         mask_in = job_in.mask;
      end else if (pop) begin
         mask_in = mask_ff & ~low_bit;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         sym0_ff     <= job_in.sym0;
         sym1_ff     <= job_in.sym1;
         msg_last_ff <= job_in.msg_last;
      end
      if (pop) begin
         out_char_ff     <= pick_char;
         out_run_last_ff <= one_left;
         out_end_ff      <= one_left && msg_last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_char        = out_char_ff;
   assign rsp_run_last    = out_run_last_ff;
   assign rsp_message_end = out_end_ff;

   // a new request never overwrites pending characters
   assert property (@(posedge clock) disable iff (reset)
      load && busy |-> pop && one_left)
      else $error("b64e_serial: request loaded over pending characters");

   // a character moved out shows up as a valid response
   assert property (@(posedge clock) disable iff (reset)
      pop |=> out_valid_ff)
      else $error("b64e_serial: popped character lost");

   // message end only on the last character of a request
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_end_ff |-> out_run_last_ff)
      else $error("b64e_serial: message end without run end");

   // a loaded request with characters keeps the serializer busy
   assert property (@(posedge clock) disable iff (reset)
      load && job_in.mask != '0 |=> busy)
      else $error("b64e_serial: loaded request dropped");

endmodule
